FILE: rtl/binary_majority_filter_3x3_defines.svh
// Assertion macros shared by the majority filter RTL.
// Needs clk and rst_n in the scope of every use.
`ifndef BINARY_MAJORITY_FILTER_3X3_DEFINES_SVH
`define BINARY_MAJORITY_FILTER_3X3_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define BMF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmf_pkg.sv
// Shared constants, item type and window functions of the 3x3 majority filter.
// No dependencies.
`default_nettype none

package bmf_pkg;

    localparam int DEF_MAX_LINE   = 4096;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int RESET_WIDTH    = 64;
    localparam int RESET_HEIGHT   = 64;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int ROW_W          = $clog2(HEIGHT_LIMIT + 2);
    localparam int OROW_W         = $clog2(HEIGHT_LIMIT);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Per-item control handed from the position logic to the window stage.
    typedef struct packed {
        logic active;      // row still shifts a column into the window
        logic in_frame;    // pixel belongs to the frame and goes to the line store
        logic pix;
        logic first_col;   // result comes from the window before the shift
        logic emit;
        logic last;
        logic row_ge1;
        logic row_ge2;
        logic keep_top;
        logic keep_bot;
        logic keep_left;
        logic keep_right;
    } bmf_item_t;

    // Window bit rs*3+cs: rs 0 top .. 2 bottom, cs 0 left .. 2 right.
    function automatic logic [8:0] shift_column(logic [8:0] win, logic top,
                                                logic mid, logic bot);
        return {bot, win[8:7], mid, win[5:4], top, win[2:1]};
    endfunction

    function automatic logic majority(logic [8:0] win, logic kt, logic kb,
                                      logic kl, logic kr);
        logic [2:0] row_ok;
        logic [2:0] col_ok;
        logic [3:0] cnt;
        logic [3:0] total;
        row_ok = {kb, 1'b1, kt};
        col_ok = {kr, 1'b1, kl};
        cnt    = '0;
        total  = '0;
        for (int rs = 0; rs < 3; rs++)
        begin
            for (int cs = 0; cs < 3; cs++)
            begin
                if (row_ok[rs] && col_ok[cs])
                begin
                    total = total + 4'd1;
                    cnt   = cnt + {3'd0, win[rs*3+cs]};
                end
            end
        end
        return {cnt, 1'b0} > {1'b0, total};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/binary_majority_filter_3x3.sv
// Binary 3x3 majority filter, one pixel or flush transfer per clock while the output is not stalled.
// Each transfer is registered in the window stage; its result enters the output register when that stage advances.
// Accepts one item per cycle unless a held output result stalls the window stage.
// Results lag the pixel stream by one row plus one pixel; W+1 flushes drain a frame.
// Reset: positions and window cleared, width 64 (at most MAX_LINE) and height 64; line store not cleared.
`include "binary_majority_filter_3x3_defines.svh"
`default_nettype none

module binary_majority_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_LINE = DEF_MAX_LINE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic                 pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      pixel_out,
    output logic                      frame_end,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_LINE);
    localparam int DEF_W = (RESET_WIDTH > MAX_LINE) ? MAX_LINE : RESET_WIDTH;

    logic [COL_W:0]    eff_w_reg;
    logic [ROW_W-1:0]  eff_h_reg;
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic              s1_valid_reg, s1_valid_next;
    bmf_item_t         s1_item_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    logic              out_valid_reg;
    logic              pixel_out_reg;
    logic              frame_end_reg;

    logic              cfg_restart;
    logic              take;
    logic              go;
    logic              s1_advance;
    logic [COL_W-1:0]  col;
    logic [COL_W:0]    col_ext;
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    ocol_inc;
    logic [ROW_W-1:0]  orow_inc;
    logic              in_frame;
    logic              s0_last;
    bmf_item_t         s0_item;
    logic [1:0]        line;
    logic              result;

    // ---- configuration ----
    always_comb
    begin
        case (cfg_index)
            REG_FRAME_WIDTH:  cfg_restart = cfg_wr_en;
            REG_FRAME_HEIGHT: cfg_restart = cfg_wr_en;
            default:          cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= (COL_W+1)'(DEF_W);
            eff_h_reg <= ROW_W'(RESET_HEIGHT);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (cfg_data == '0)
                        eff_w_reg <= (COL_W+1)'(1);
                    else if (32'(cfg_data) > MAX_LINE)
                        eff_w_reg <= (COL_W+1)'(MAX_LINE);
                    else
                        eff_w_reg <= (COL_W+1)'(cfg_data);
                end
                REG_FRAME_HEIGHT:
                begin
                    if (cfg_data == '0)
                        eff_h_reg <= ROW_W'(1);
                    else if (32'(cfg_data) > HEIGHT_LIMIT)
                        eff_h_reg <= ROW_W'(HEIGHT_LIMIT);
                    else
                        eff_h_reg <= ROW_W'(cfg_data);
                end
                default:
                begin
                    eff_w_reg <= eff_w_reg;
                end
            endcase
        end
    end

    // ---- position logic on the input transfer ----
    always_comb
    begin
        col_ext  = ({1'b0, in_col_reg} >= eff_w_reg) ? '0 : {1'b0, in_col_reg};
        col      = col_ext[COL_W-1:0];
        col_inc  = col_ext + (COL_W+1)'(1);
        ocol_inc = {1'b0, out_col_reg} + (COL_W+1)'(1);
        orow_inc = {1'b0, out_row_reg} + ROW_W'(1);
        in_frame = in_row_reg < eff_h_reg;

        take = in_valid && in_ready;
        // drop an early flush
        go   = take && !(in_frame && (operation == OP_FLUSH));

        s0_item.active     = in_row_reg <= eff_h_reg;
        s0_item.in_frame   = in_frame;
        s0_item.pix        = pixel_in;
        s0_item.first_col  = (col == '0);
        s0_item.row_ge1    = in_row_reg >= ROW_W'(1);
        s0_item.row_ge2    = in_row_reg >= ROW_W'(2);
        s0_item.emit       = s0_item.row_ge2 || (s0_item.row_ge1 && (col != '0));
        s0_item.keep_top   = out_row_reg != '0;
        s0_item.keep_bot   = orow_inc < eff_h_reg;
        s0_item.keep_left  = out_col_reg != '0;
        s0_item.keep_right = ocol_inc < eff_w_reg;
        s0_last            = s0_item.emit && !s0_item.keep_bot && !s0_item.keep_right;
        s0_item.last       = s0_last;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_restart || (go && s0_last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (go)
        begin
            if (col_inc >= eff_w_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = col_inc[COL_W-1:0];
            end
            if (s0_item.emit)
            begin
                if (!s0_item.keep_right)
                begin
                    out_col_next = '0;
                    out_row_next = orow_inc[OROW_W-1:0];
                end
                else
                begin
                    out_col_next = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---- window stage ----
    assign s1_advance = s1_valid_reg && (!s1_item_reg.emit || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (go)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_item_reg <= s0_item;
            s1_addr_reg <= col;
        end
    end

    bmf_line_store #(
        .DEPTH  (MAX_LINE),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (go),
        .rd_addr (col),
        .wr_en   (s1_advance && s1_item_reg.in_frame),
        .wr_addr (s1_addr_reg),
        .wr_data ({line[0], s1_item_reg.pix}),
        .rd_data (line)
    );

    bmf_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_restart),
        .advance (s1_advance),
        .item    (s1_item_reg),
        .line    (line),
        .result  (result)
    );

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_item_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_item_reg.emit)
        begin
            pixel_out_reg <= result;
            frame_end_reg <= s1_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

    logic [COL_W:0]  in_col_chk;
    logic [ROW_W-1:0] out_row_chk;
    assign in_col_chk  = {1'b0, in_col_reg};
    assign out_row_chk = {1'b0, out_row_reg};

    `BMF_ASSERT_NEXT(a_restart_after_last, go && s0_last && !cfg_restart,
        (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0),
        "positions not cleared after the last pixel of a frame")
    `BMF_ASSERT_ALWAYS(a_in_col_bound, in_col_chk < eff_w_reg,
        "input column beyond frame width")
    `BMF_ASSERT_ALWAYS(a_out_row_bound, out_row_chk < eff_h_reg,
        "output row beyond frame height")

endmodule

`default_nettype wire

FILE: rtl/bmf_line_store.sv
// Two-bit line store: one synchronous write port and one registered read
// port. Forwards a write that lands on the address read.
`include "binary_majority_filter_3x3_defines.svh"
`default_nettype none

module bmf_line_store
    import bmf_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_LINE,
    parameter int ADDR_W = $clog2(DEF_MAX_LINE)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [1:0]        wr_data,
    output logic [1:0]             rd_data
);

    logic [1:0] store_reg [DEPTH];
    logic [1:0] rd_data_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= store_reg[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    `BMF_ASSERT_NEXT(a_forward_same_addr, rd_en && wr_en && (rd_addr == wr_addr),
        rd_data === $past(wr_data), "line store read missed a same-cycle write")

endmodule

`default_nettype wire

FILE: rtl/bmf_window.sv
// 3x3 window register and majority evaluation for one item per cycle while advance is high.
// Depends on bmf_pkg for the item type and window functions.
`default_nettype none

module bmf_window
    import bmf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      clear,
    input  wire logic      advance,
    input  wire bmf_item_t item,
    input  wire logic [1:0] line,
    output logic           result
);

    logic [8:0] win_reg;
    logic [8:0] win_next;
    logic [8:0] shifted;
    logic [8:0] drained;
    logic       top_bit;
    logic       mid_bit;
    logic       bot_bit;

    always_comb
    begin
        top_bit = item.row_ge2 ? line[1] : 1'b0;
        mid_bit = item.row_ge1 ? line[0] : 1'b0;
        bot_bit = item.in_frame ? item.pix : 1'b0;
        shifted = item.active ? shift_column(win_reg, top_bit, mid_bit, bot_bit) : win_reg;
        // first column of a row: the pending result is the previous row's last pixel
        drained = shift_column(win_reg, 1'b0, 1'b0, 1'b0);
        result  = item.first_col
                ? majority(drained, item.keep_top, item.keep_bot, item.keep_left,
                           item.keep_right)
                : majority(shifted, item.keep_top, item.keep_bot, item.keep_left,
                           item.keep_right);
    end

    always_comb
    begin
        win_next = win_reg;
        if (clear)
        begin
            win_next = '0;
        end
        else if (advance)
        begin
            win_next = item.last ? 9'd0 : shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the 3x3 binary majority filter.
// Predicts every filtered pixel in a scoreboard class; needs bmf_pkg and the filter RTL.
`timescale 1ns / 1ps

module testbench;
    import bmf_pkg::*;

    localparam int ITEMS = 800;

    typedef struct packed {
        logic pix;
        logic last;
    } filtered_pixel_t;

    // Tracks frame position, line rows and window; holds the pixels still owed by the filter.
    class majority_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [1:0]       rows_store [DEF_MAX_LINE];
        logic [8:0]       window;
        int unsigned      in_row;
        int unsigned      in_col;
        int unsigned      out_row;
        int unsigned      out_col;
        filtered_pixel_t  owed_q [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      ends;

        function new();
            width_reg  = CFG_W'(RESET_WIDTH);
            height_reg = CFG_W'(RESET_HEIGHT);
            foreach (rows_store[i])
                rows_store[i] = 2'b00;
            errors  = 0;
            checked = 0;
            ends    = 0;
            restart();
        endfunction

        function void restart();
            window  = '0;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > DEF_MAX_LINE)
                return DEF_MAX_LINE;
            return v;
        endfunction

        function int unsigned cols();
            return clamp_size(width_reg);
        endfunction

        function int unsigned rows();
            return clamp_size(height_reg);
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_WIDTH)
                width_reg = val;
            else if (idx == REG_FRAME_HEIGHT)
                height_reg = val;
            restart();
        endfunction

        // Shift one column in from the right side: bit rs*3+cs, rs top..bottom.
        function logic [8:0] push_column(logic [8:0] win, logic top, logic mid, logic bot);
            logic [8:0] r;
            r[2:0] = {top, win[2:1]};
            r[5:3] = {mid, win[5:4]};
            r[8:6] = {bot, win[8:7]};
            return r;
        endfunction

        function logic vote(logic [8:0] win, int unsigned orow, int unsigned ocol,
                            int unsigned w, int unsigned h);
            int unsigned ink;
            int unsigned seen;
            ink  = 0;
            seen = 0;
            for (int rs = 0; rs < 3; rs++)
            begin
                for (int cs = 0; cs < 3; cs++)
                begin
                    if ((rs == 0 && orow == 0) || (rs == 2 && orow + 1 >= h))
                        continue;
                    if ((cs == 0 && ocol == 0) || (cs == 2 && ocol + 1 >= w))
                        continue;
                    seen++;
                    ink += win[rs*3+cs];
                end
            end
            return (2 * ink > seen);
        endfunction

        // Returns 0 when the filter drops the transfer (flush while pixels are still due).
        function bit note_item(logic op, logic pix);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            logic        in_frame;
            logic        emit;
            logic        top;
            logic        mid;
            filtered_pixel_t res;
            w        = cols();
            h        = rows();
            in_frame = (in_row < h);
            if (in_frame && op == OP_FLUSH)
                return 0;
            c    = (in_col >= w) ? 0 : in_col;
            emit = (in_row * w + c >= w + 1);
            res  = '0;
            // first column: the result comes from the window before this shift
            if (emit && c == 0)
                res.pix = vote(push_column(window, 1'b0, 1'b0, 1'b0), out_row, out_col, w, h);
            if (in_row <= h)
            begin
                top    = (in_row >= 2) ? rows_store[c][1] : 1'b0;
                mid    = (in_row >= 1) ? rows_store[c][0] : 1'b0;
                window = push_column(window, top, mid, in_frame ? pix : 1'b0);
                if (in_frame)
                    rows_store[c] = {rows_store[c][0], pix};
            end
            if (emit && c != 0)
                res.pix = vote(window, out_row, out_col, w, h);
            in_col = c + 1;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!emit)
                return 1;
            res.last = (out_row + 1 >= h && out_col + 1 >= w);
            if (!res.last)
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            owed_q = {owed_q, res};
            if (res.last)
                restart();
            return 1;
        endfunction

        function void report(string what);
            errors++;
            $display("MISMATCH %0d at %0t ns: %s", errors, $time, what);
        endfunction

        function void check_result(logic pix, logic fe);
            filtered_pixel_t exp;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected result pixel_out=%0b frame_end=%0b", pix, fe));
                return;
            end
            exp = owed_q.pop_front();
            checked++;
            if (fe === 1'b1)
                ends++;
            if (pix !== exp.pix)
                report($sformatf("result %0d: pixel_out=%0b, predicted %0b",
                                 checked, pix, exp.pix));
            if (fe !== exp.last)
                report($sformatf("result %0d: frame_end=%0b, predicted %0b",
                                 checked, fe, exp.last));
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 operation = OP_PIXEL;
    logic                 pixel_in  = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 pixel_out;
    logic                 frame_end;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    majority_scoreboard sb = new();
    bit          steady  = 1'b0;
    int unsigned density = 50;
    int unsigned fed     = 0;
    int unsigned setups  = 0;

    binary_majority_filter_3x3 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .frame_end (frame_end),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Check each output transfer, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(pixel_out, frame_end);
        out_ready <= steady || ($urandom_range(99) >= 25);
    end

    function automatic logic ink();
        return ($urandom_range(99) < density);
    endfunction

    task automatic send_item(input logic op, input logic pix);
        while (!steady && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        pixel_in  <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (sb.note_item(op, pix))
            fed++;
    endtask

    // Drop valid, wait for every owed pixel, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        sb.write_reg(REG_FRAME_WIDTH, w);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        sb.write_reg(REG_FRAME_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        setups++;
    endtask

    // Send up to cut pixels; a full frame also gets its drain tail.
    task automatic send_frame(input int unsigned cut);
        int unsigned total;
        int unsigned w;
        w     = sb.cols();
        total = w * sb.rows();
        for (int unsigned i = 0; i < total && i < cut; i++)
        begin
            if ($urandom_range(99) < 4)
                send_item(OP_FLUSH, 1'($urandom_range(1)));
            send_item(OP_PIXEL, ink());
        end
        if (cut < total)
            return;
        // late pixels act as flushes
        for (int unsigned i = 0; i <= w; i++)
            send_item(($urandom_range(9) < 3) ? OP_PIXEL : OP_FLUSH, 1'($urandom_range(1)));
        if ($urandom_range(9) == 0)
            send_item(OP_FLUSH, 1'($urandom_range(1)));
    endtask

    initial
    begin
        logic [8:0]  pattern;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned cut;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: partial frame, then abandon it with a register write.
        send_frame(70);
        settle();

        // 3x3 frame: corners, edges, center; early flush mid-frame, late pixels in the tail.
        configure(13'd3, 13'd3);
        pattern = 9'b110_010_011;
        for (int i = 0; i < 9; i++)
        begin
            send_item(OP_PIXEL, pattern[i]);
            if (i == 4)
                send_item(OP_FLUSH, 1'b1);
        end
        send_item(OP_FLUSH, 1'b0);
        send_item(OP_PIXEL, 1'b1);
        send_item(OP_FLUSH, 1'b1);
        send_item(OP_PIXEL, 1'b0);
        settle();

        // Zero sizes act as 1x1.
        configure(13'd0, 13'd0);
        send_item(OP_PIXEL, 1'b1);
        send_item(OP_FLUSH, 1'b1);
        send_item(OP_PIXEL, 1'b1);
        settle();

        // Mid-size frame with no idling on either side.
        steady  = 1'b1;
        density = 60;
        configure(13'd24, 13'd6);
        send_frame(32'hFFFF_FFFF);
        settle();
        steady  = 1'b0;

        while (fed < ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            else if (sel < 85)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 4);
            end
            else if (sel < 92)
            begin
                w = $urandom_range(0, 3);
                h = $urandom_range(0, 3);
            end
            else
            begin
                w = $urandom_range(1, 3);
                h = $urandom_range(9, 30);
            end
            configure(CFG_W'(w), CFG_W'(h));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                case ($urandom_range(3))
                    0: density = 10;
                    1: density = 50;
                    2: density = 90;
                    default: density = $urandom_range(100);
                endcase
                if ($urandom_range(9) == 0)
                begin
                    cut = $urandom_range(sb.cols() * sb.rows() - 1);
                    send_frame(cut);
                    break;
                end
                send_frame(32'hFFFF_FFFF);
            end
            settle();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted pixels never arrived", sb.pending()));
        $display("Run covered %0d filtered pixels and %0d frame ends over %0d size settings,",
                 sb.checked, sb.ends, setups);
        $display("from 1x1 and zero sizes up to 40-pixel rows, with random stalls; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout: the filter stopped moving transfers");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: binary_majority_filter_3x3.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_line_store.sv
rtl/bmf_window.sv
rtl/binary_majority_filter_3x3.sv
tb/testbench.sv
